>>> rtl/core/qle_pkg.sv
// shared types, constants and helper functions of the q-learning engine
package qle_pkg;

  localparam int NUM_ACT     = 6;
  localparam int DIST_LEVELS = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int ROWS        = NUM_ACT * NUM_ACT * DIST_LEVELS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int ACT_W       = 3;
  localparam int DIST_W      = 12;
  localparam int VAL_W       = 32;
  localparam int PCT_W       = 7;
  localparam int RATE_W      = 17;
  localparam int TIE_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 40;

  // action codes
  localparam logic [ACT_W-1:0] ACT_IDLE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_JUMP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUNCH   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_KICK    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BACK    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd5;

  localparam logic [PCT_W-1:0]  EXPLORE_RESET    = 7'd10;
  localparam logic [RATE_W-1:0] LEARN_RATE_RESET = 17'd32768;
  localparam logic [RATE_W-1:0] DISCOUNT_RESET   = 17'd58982;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPLORE    = 2'd0,
    CFG_LEARN_RATE = 2'd1,
    CFG_DISCOUNT   = 2'd2
  } cfg_idx_e;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t [NUM_ACT-1:0] row_t;
  typedef logic [ROW_W-1:0] row_idx_t;

  typedef struct packed {
    logic gamma_en;
    logic target_en;
    logic alpha_en;
  } arith_ctl_t;

  function automatic logic [ACT_W-1:0] clamp_act(input logic [ACT_W-1:0] a);
    return (a > ACT_FORWARD) ? ACT_FORWARD : a;
  endfunction

  function automatic row_idx_t row_index(input logic [ACT_W-1:0] my,
                                         input logic [ACT_W-1:0] opp,
                                         input logic [DIST_W-1:0] dst);
    logic [5:0]        pair;
    logic [DIST_W-1:0] d_c;
    pair = 6'(clamp_act(my)) * 6'(NUM_ACT) + 6'(clamp_act(opp));
    d_c  = (dst > DIST_W'(DIST_LEVELS - 1)) ? DIST_W'(DIST_LEVELS - 1) : dst;
    return ROW_W'(pair) * ROW_W'(DIST_LEVELS) + ROW_W'(d_c);
  endfunction

  function automatic logic [ACT_W-1:0] explore_act(input logic [ACT_W-1:0] r);
    logic [ACT_W-1:0] a;
    case (r)
      3'd0:    a = ACT_BACK;
      3'd1:    a = ACT_FORWARD;
      3'd2:    a = ACT_KICK;
      3'd3:    a = ACT_PUNCH;
      3'd4:    a = ACT_JUMP;
      default: a = ACT_IDLE;
    endcase
    return a;
  endfunction

  // remainder of an 8-bit draw by a tie count of one to six, via reciprocals
  function automatic logic [ACT_W-1:0] tie_mod(input logic [TIE_W-1:0] r,
                                               input logic [ACT_W-1:0] cnt);
    logic [23:0] prod;
    logic [7:0]  q;
    logic [10:0] qd;
    logic [ACT_W-1:0] rem;
    prod = '0;
    q    = '0;
    qd   = '0;
    rem  = '0;
    case (cnt)
      3'd2: rem = {2'b00, r[0]};
      3'd3: begin
        prod = 24'(r) * 24'd21846;
        q    = prod[23:16];
        qd   = 11'(q) * 11'd3;
        rem  = ACT_W'(11'(r) - qd);
      end
      3'd4: rem = {1'b0, r[1:0]};
      3'd5: begin
        prod = 24'(r) * 24'd13108;
        q    = prod[23:16];
        qd   = 11'(q) * 11'd5;
        rem  = ACT_W'(11'(r) - qd);
      end
      3'd6: begin
        prod = 24'(r) * 24'd10923;
        q    = prod[23:16];
        qd   = 11'(q) * 11'd6;
        rem  = ACT_W'(11'(r) - qd);
      end
      default: rem = '0;
    endcase
    return rem;
  endfunction

  // minimum of a row as a three-level tree
  function automatic val_t row_min(input row_t row);
    val_t m01, m23, m45, m03;
    m01 = (row[1] < row[0]) ? row[1] : row[0];
    m23 = (row[3] < row[2]) ? row[3] : row[2];
    m45 = (row[5] < row[4]) ? row[5] : row[4];
    m03 = (m23 < m01) ? m23 : m01;
    return (m45 < m03) ? m45 : m03;
  endfunction

  function automatic val_t sat_val(input logic signed [SUM_W-1:0] v);
    val_t r;
    if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
      r = v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tabular_q_learning_engine_core.sv
// top level of the q-learning engine: sequencer, action choice and ports
//
// Input channel (in_valid_i / in_stall_o) takes one request per beat: a
// choose request (req_type 0) or a learn request (req_type 1). Output channel
// (out_valid_o / out_stall_i) returns exactly one result beat per request.
// Configuration writes (cfg_valid_i / cfg_ready_o) set explore percent,
// learn rate and discount; the port is always ready.
// After reset the engine runs a clearing pass that zeroes the q-table, one
// row of six values a cycle, 36864 rows in all; input stays stalled meanwhile.
// A choose request steps through row read, minimum and tie pick; its result
// then enters the output register. For a learn request the
// next-state row and the current row are read through the single read port,
// then the discount product, the target and the learn-rate product each take
// a registered step before the row is written back.
// The result sits in an output register: the next request is accepted while
// it waits. If the receiver stalls, a finished request holds in its last step
// (and the table write waits with it) until the output register frees.
module tabular_q_learning_engine_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [qle_pkg::ACT_W-1:0]  cur_my_action_i,
  input  logic [qle_pkg::ACT_W-1:0]  cur_opp_action_i,
  input  logic [qle_pkg::DIST_W-1:0] cur_distance_i,
  input  logic [qle_pkg::ACT_W-1:0]  taken_action_i,
  input  logic signed [qle_pkg::VAL_W-1:0] reward_i,
  input  logic [qle_pkg::ACT_W-1:0]  next_my_action_i,
  input  logic [qle_pkg::ACT_W-1:0]  next_opp_action_i,
  input  logic [qle_pkg::DIST_W-1:0] next_distance_i,
  input  logic [qle_pkg::PCT_W-1:0]  rand_explore_i,
  input  logic [qle_pkg::ACT_W-1:0]  rand_action_i,
  input  logic [qle_pkg::TIE_W-1:0]  rand_tie_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [qle_pkg::ACT_W-1:0]  chosen_action_o,
  output logic                       explored_o,
  output logic signed [qle_pkg::VAL_W-1:0] new_value_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [qle_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qle_pkg::RATE_W-1:0] cfg_data_i
);
  import qle_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MIN    = 8'b0000_0100,
    S_TIE    = 8'b0000_1000,
    S_GAMMA  = 8'b0001_0000,
    S_TARGET = 8'b0010_0000,
    S_ALPHA  = 8'b0100_0000,
    S_WRITE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  row_idx_t clr_q, clr_d;

  logic [PCT_W-1:0]  explore_q;
  logic [RATE_W-1:0] learn_rate_q, discount_q;

  logic              req_q;
  row_idx_t          cur_row_q;
  logic [ACT_W-1:0]  act_q, rnd_act_q;
  val_t              reward_q, min_q, old_q;
  logic              expl_q;
  logic [TIE_W-1:0]  tie_q;

  logic              out_valid_q;
  logic [ACT_W-1:0]  out_act_q;
  logic              out_expl_q;
  val_t              out_val_q;

  logic              accept, out_free, out_load;
  logic [ACT_W-1:0]  out_act_d;
  val_t              out_val_d;

  logic              rd_en, wr_en;
  row_idx_t          rd_addr, wr_addr;
  row_t              rd_row, wr_row;
  arith_ctl_t        actl;
  val_t              new_value;

  logic [NUM_ACT-1:0] eq;
  logic [ACT_W-1:0]   tie_cnt, tie_pick, seen, pick_act;
  logic               found;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      explore_q    <= EXPLORE_RESET;
      learn_rate_q <= LEARN_RATE_RESET;
      discount_q   <= DISCOUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EXPLORE:    explore_q    <= cfg_data_i[PCT_W-1:0];
        CFG_LEARN_RATE: learn_rate_q <= cfg_data_i;
        CFG_DISCOUNT:   discount_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ROW_W'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE:   if (accept) state_d = S_MIN;
      S_MIN:    state_d = req_q ? S_GAMMA : S_TIE;
      S_TIE:    if (out_free) state_d = S_IDLE;
      S_GAMMA:  state_d = S_TARGET;
      S_TARGET: state_d = S_ALPHA;
      S_ALPHA:  state_d = S_WRITE;
      S_WRITE:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      cur_row_q <= row_index(cur_my_action_i, cur_opp_action_i, cur_distance_i);
      act_q     <= clamp_act(taken_action_i);
      reward_q  <= reward_i;
      expl_q    <= !req_type_i && (rand_explore_i < explore_q);
      rnd_act_q <= explore_act(rand_action_i);
      tie_q     <= rand_tie_i;
    end
    if (state_q == S_MIN) begin
      min_q <= row_min(rd_row);
    end
    if (state_q == S_GAMMA) begin
      old_q <= rd_row[act_q];
    end
  end

  // choose reads the current row, learn reads the next-state row first
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_row_q;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = req_type_i
        ? row_index(next_my_action_i, next_opp_action_i, next_distance_i)
        : row_index(cur_my_action_i, cur_opp_action_i, cur_distance_i);
    end else if (state_q == S_MIN && req_q) begin
      rd_en = 1'b1;
    end
  end

  qle_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_row)
  );

  assign actl.gamma_en  = (state_q == S_GAMMA);
  assign actl.target_en = (state_q == S_TARGET);
  assign actl.alpha_en  = (state_q == S_ALPHA);

  qle_arith u_arith (
    .clk_i        (clk_i),
    .ctl_i        (actl),
    .min_q_i      (min_q),
    .old_i        (old_q),
    .reward_i     (reward_q),
    .learn_rate_i (learn_rate_q),
    .discount_i   (discount_q),
    .new_value_o  (new_value)
  );

  // write-back row: the taken action's entry replaced, or all zeros while clearing
  always_comb begin
    for (int i = 0; i < NUM_ACT; i++) begin
      wr_row[i] = (act_q == ACT_W'(i)) ? new_value : rd_row[i];
    end
    if (state_q == S_CLEAR) begin
      wr_row = '0;
    end
  end

  assign wr_en   = (state_q == S_CLEAR) || (state_q == S_WRITE && out_free);
  assign wr_addr = (state_q == S_CLEAR) ? clr_q : cur_row_q;

  // tie break among equal minima in ascending action order
  always_comb begin
    tie_cnt = '0;
    for (int i = 0; i < NUM_ACT; i++) begin
      eq[i]   = (rd_row[i] == min_q);
      tie_cnt = tie_cnt + ACT_W'(eq[i]);
    end
    tie_pick = tie_mod(tie_q, tie_cnt);
    seen     = '0;
    pick_act = '0;
    found    = 1'b0;
    for (int i = 0; i < NUM_ACT; i++) begin
      if (eq[i] && !found) begin
        if (seen == tie_pick) begin
          pick_act = ACT_W'(i);
          found    = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
  end

  // output register
  assign out_load  = out_free && (state_q == S_TIE || state_q == S_WRITE);
  assign out_act_d = (state_q == S_WRITE) ? act_q : (expl_q ? rnd_act_q : pick_act);
  assign out_val_d = (state_q == S_WRITE) ? new_value : (expl_q ? '0 : min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_act_q  <= out_act_d;
      out_expl_q <= (state_q == S_TIE) && expl_q;
      out_val_q  <= out_val_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = out_act_q;
  assign explored_o      = out_expl_q;
  assign new_value_o     = out_val_q;

  a_expl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && explored_o |-> new_value_o == '0)
    else $error("explored result carries a nonzero value");

  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chosen_action_o <= ACT_FORWARD)
    else $error("chosen action out of range");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !out_valid_q)
    else $error("result beat during clearing pass");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_TIE || state_q == S_WRITE))
    else $error("result beat without a finishing step");

endmodule

>>> rtl/core/qle_table.sv
// q-table row memory: one write port, one registered read port
module qle_table (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  qle_pkg::row_idx_t wr_addr_i,
  input  qle_pkg::row_t     wr_data_i,
  input  logic              rd_en_i,
  input  qle_pkg::row_idx_t rd_addr_i,
  output qle_pkg::row_t     rd_data_o
);
  import qle_pkg::*;

  row_t mem [ROWS];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/qle_arith.sv
// learn datapath: discounted target, alpha step and saturated new value (the reward itself where the old value is zero)
module qle_arith (
  input  logic                          clk_i,
  input  qle_pkg::arith_ctl_t           ctl_i,
  input  qle_pkg::val_t                 min_q_i,
  input  qle_pkg::val_t                 old_i,
  input  qle_pkg::val_t                 reward_i,
  input  logic [qle_pkg::RATE_W-1:0]    learn_rate_i,
  input  logic [qle_pkg::RATE_W-1:0]    discount_i,
  output qle_pkg::val_t                 new_value_o
);
  import qle_pkg::*;

  logic signed [RATE_W+VAL_W:0]   prod_g_d, prod_g_q;
  logic signed [RATE_W+VAL_W+1:0] prod_a_d, prod_a_q;
  logic signed [VAL_W:0]          diff;
  logic signed [SUM_W-1:0]        tgt_sum, new_sum;
  val_t                           target_d, target_q;

  assign prod_g_d = $signed({1'b0, discount_i}) * min_q_i;

  // arithmetic shift right floors, as the truncation needs
  assign tgt_sum  = SUM_W'(reward_i) + SUM_W'(prod_g_q >>> FRAC_BITS);
  assign target_d = sat_val(tgt_sum);

  assign diff     = {target_q[VAL_W-1], target_q} - {old_i[VAL_W-1], old_i};
  assign prod_a_d = $signed({1'b0, learn_rate_i}) * diff;

  assign new_sum     = SUM_W'(old_i) + SUM_W'(prod_a_q >>> FRAC_BITS);
  assign new_value_o = (old_i == '0) ? reward_i : sat_val(new_sum);

  always_ff @(posedge clk_i) begin
    if (ctl_i.gamma_en) begin
      prod_g_q <= prod_g_d;
    end
    if (ctl_i.target_en) begin
      target_q <= target_d;
    end
    if (ctl_i.alpha_en) begin
      prod_a_q <= prod_a_d;
    end
  end

endmodule
